FILE: rtl/core/rhsv_pkg.sv
// Shared widths, constants and the divider payload type for the RGB to HSV core.
// No dependencies; every other file in rtl/core imports this package.
package rhsv_pkg;

	// Channel width of one color component
	localparam int PIX_W = 8;

	// Quotient bits and divider stage split
	localparam int Q_BITS         = 8;
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES     = Q_BITS / BITS_PER_STAGE;

	// Hue is floor(85 * N / (2 * chroma)), N = sector position in [0, 6 * chroma)
	localparam int HUE_MUL = 255 * 60 / 180;
	localparam int SECT_W  = 11;
	localparam int HNUM_W  = 17;
	localparam int HDEN_W  = PIX_W + 1;

	// Saturation is floor(255 * chroma / max)
	localparam int SNUM_W = 2 * PIX_W;
	localparam int SDEN_W = PIX_W;

	// Running state of both long divisions plus the value channel
	typedef struct packed {
		logic [HNUM_W-1:0] hue_rem;
		logic [HDEN_W-1:0] hue_den;
		logic [Q_BITS-1:0] hue_q;
		logic [SNUM_W-1:0] sat_rem;
		logic [SDEN_W-1:0] sat_den;
		logic [Q_BITS-1:0] sat_q;
		logic [PIX_W-1:0]  value;
	} div_t;

endpackage

FILE: rtl/core/rhsv_rgb_if.sv
// Valid/ready channel carrying one RGB pixel.
// Depends on rhsv_pkg for the channel width.
interface rhsv_rgb_if import rhsv_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

FILE: rtl/core/rhsv_hsv_if.sv
// Valid/ready channel carrying one HSV pixel.
// Depends on rhsv_pkg for the channel width.
interface rhsv_hsv_if import rhsv_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] hue;
	logic [PIX_W-1:0] saturation;
	logic [PIX_W-1:0] value;

	modport source (output valid, hue, saturation, value, input ready);
	modport sink (input valid, hue, saturation, value, output ready);
endinterface

FILE: rtl/core/rhsv_front.sv
// Front end of the RGB to HSV pipeline: max/min and hue sector (stage 1),
// dividend and divisor setup for both divisions (stage 2).
// Depends on rhsv_pkg and rhsv_rgb_if.
module rhsv_front import rhsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rhsv_rgb_if.sink   rgb,
	output logic       valid,
	input  logic       ready,
	output div_t       data
);

	logic              valid_s1;
	logic [PIX_W-1:0]  value_s1;
	logic [PIX_W-1:0]  chroma_s1;
	logic [SECT_W-1:0] sect_s1;
	logic              valid_s2;
	div_t              data_s2;

	logic              ready_s1;
	logic              ready_s2;
	logic [PIX_W-1:0]  mx;
	logic [PIX_W-1:0]  mn;
	logic [PIX_W-1:0]  chroma;
	logic signed [11:0] diff;
	logic signed [11:0] base;
	logic signed [11:0] sect;
	logic [11:0]       c_ext;
	div_t              nxt_s2;

	// Stage handshake: a stage takes new data when empty or when it drains
	assign ready_s2  = !valid_s2 || ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign rgb.ready = ready_s1;

	// Largest and smallest channel, hue sector position with blue > green > red on ties
	always_comb begin
		mx = (rgb.red > rgb.green) ? rgb.red : rgb.green;
		mx = (mx > rgb.blue) ? mx : rgb.blue;
		mn = (rgb.red < rgb.green) ? rgb.red : rgb.green;
		mn = (mn < rgb.blue) ? mn : rgb.blue;
		chroma = mx - mn;
		c_ext  = {4'b0, chroma};
		if (mx == rgb.blue) begin
			diff = $signed({4'b0, rgb.red}) - $signed({4'b0, rgb.green});
			base = $signed(c_ext << 2);
		end else if (mx == rgb.green) begin
			diff = $signed({4'b0, rgb.blue}) - $signed({4'b0, rgb.red});
			base = $signed(c_ext << 1);
		end else begin
			diff = $signed({4'b0, rgb.green}) - $signed({4'b0, rgb.blue});
			base = '0;
		end
		sect = base + diff;
		// Wrap a negative red-sector angle by a full turn
		if (sect < 0) begin
			sect = sect + $signed((c_ext << 2) + (c_ext << 1));
		end
	end

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= rgb.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rgb.valid && ready_s1) begin
			value_s1  <= mx;
			chroma_s1 <= chroma;
			sect_s1   <= sect[SECT_W-1:0];
		end
	end

	// Dividends and divisors; a zero divisor becomes one so the zero dividend yields zero
	always_comb begin
		nxt_s2.hue_rem = HNUM_W'(sect_s1) * HNUM_W'(HUE_MUL);
		nxt_s2.hue_den = (chroma_s1 == '0) ? HDEN_W'(1) : {chroma_s1, 1'b0};
		nxt_s2.hue_q   = '0;
		nxt_s2.sat_rem = {chroma_s1, 8'b0} - SNUM_W'(chroma_s1);
		nxt_s2.sat_den = (value_s1 == '0) ? SDEN_W'(1) : value_s1;
		nxt_s2.sat_q   = '0;
		nxt_s2.value   = value_s1;
	end

	// Stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			data_s2 <= nxt_s2;
		end
	end

	assign valid = valid_s2;
	assign data  = data_s2;

endmodule

FILE: rtl/core/rhsv_div_stage.sv
// One register stage of the two restoring long divisions (hue and saturation),
// retiring BITS_PER_STAGE quotient bits per stage. Depends on rhsv_pkg.
module rhsv_div_stage import rhsv_pkg::*; #(
	parameter int SHIFT_HI = Q_BITS - 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	logic valid_s;
	div_t data_s;
	div_t nxt;

	assign in_ready = !valid_s || out_ready;

	// Trial-subtract the shifted divisors, shift quotient bits in from the right
	always_comb begin
		logic [HNUM_W-1:0] hue_trial;
		logic [SNUM_W-1:0] sat_trial;
		nxt = in_data;
		for (int j = 0; j < BITS_PER_STAGE; j++) begin
			hue_trial = HNUM_W'(nxt.hue_den) << (SHIFT_HI - j);
			sat_trial = SNUM_W'(nxt.sat_den) << (SHIFT_HI - j);
			if (nxt.hue_rem >= hue_trial) begin
				nxt.hue_rem = nxt.hue_rem - hue_trial;
				nxt.hue_q   = {nxt.hue_q[Q_BITS-2:0], 1'b1};
			end else begin
				nxt.hue_q   = {nxt.hue_q[Q_BITS-2:0], 1'b0};
			end
			if (nxt.sat_rem >= sat_trial) begin
				nxt.sat_rem = nxt.sat_rem - sat_trial;
				nxt.sat_q   = {nxt.sat_q[Q_BITS-2:0], 1'b1};
			end else begin
				nxt.sat_q   = {nxt.sat_q[Q_BITS-2:0], 1'b0};
			end
		end
	end

	// Hold on stall, advance otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s <= nxt;
		end
	end

	assign out_valid = valid_s;
	assign out_data  = data_s;

endmodule

FILE: rtl/core/rgb_to_hsv_pixel_core.sv
// RGB to HSV pixel converter top level: front end plus divider pipeline.
// Depends on rhsv_pkg, rhsv_rgb_if, rhsv_hsv_if, rhsv_front, rhsv_div_stage.
//
// Usage:
//   rgb  - sink channel, one RGB pixel per transaction (red, green, blue).
//   hsv  - source channel, one HSV pixel per transaction (hue, saturation, value).
//   Every input transaction yields exactly one output transaction, in order.
// Pipeline: six register stages; a pixel accepted on rgb passes stage 1, stage 2
//   and the four divider stages in order and is presented on hsv by the last one.
// Throughput: one pixel per clock while hsv.ready is high. The front end takes two
//   stages (max/min and sector, then dividend setup); the two 8-bit quotients come
//   from four stages that each retire two bits of both restoring divisions in parallel.
// Stall: each stage holds its contents while the stage after it is full and
//   not draining; rgb.ready drops only when every stage holds a pixel and
//   hsv.ready is low. Empty stages keep filling during a stall.
// Reset: arst_n clears all stage valid bits; no pixel is in flight after reset
//   and the block is ready to accept input directly after reset.
module rgb_to_hsv_pixel_core import rhsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rhsv_rgb_if.sink   rgb,
	rhsv_hsv_if.source hsv
);

	logic stg_valid [DIV_STAGES+1];
	logic stg_ready [DIV_STAGES+1];
	div_t stg_data  [DIV_STAGES+1];

	// Max/min, sector and dividend setup
	rhsv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rgb    (rgb),
		.valid  (stg_valid[0]),
		.ready  (stg_ready[0]),
		.data   (stg_data[0])
	);

	// Divider stages, most significant quotient bits first
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		rhsv_div_stage #(
			.SHIFT_HI (Q_BITS - 1 - g * BITS_PER_STAGE)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[g]),
			.in_ready  (stg_ready[g]),
			.in_data   (stg_data[g]),
			.out_valid (stg_valid[g+1]),
			.out_ready (stg_ready[g+1]),
			.out_data  (stg_data[g+1])
		);
	end

	// Last divider stage is the output register
	assign hsv.valid                = stg_valid[DIV_STAGES];
	assign stg_ready[DIV_STAGES]    = hsv.ready;
	assign hsv.hue                  = stg_data[DIV_STAGES].hue_q;
	assign hsv.saturation           = stg_data[DIV_STAGES].sat_q;
	assign hsv.value                = stg_data[DIV_STAGES].value;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for rgb_to_hsv_pixel_core: directed pixels, then random ones.
// Depends on rhsv_pkg, rhsv_rgb_if, rhsv_hsv_if and the core; results go through a local model.
`timescale 1ns / 1ps

module tb;
	import rhsv_pkg::*;

	// Sector start angles and full-turn scaling
	localparam int DEG_GREEN = 120;
	localparam int DEG_BLUE  = 240;
	localparam int DEG_SIXTH = 60;
	localparam int DEG_TURN  = 360;
	localparam int FULL      = 255;

	localparam int N_ROWS      = 21;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 12;

	typedef struct packed {
		logic [PIX_W-1:0] hue;
		logic [PIX_W-1:0] saturation;
		logic [PIX_W-1:0] value;
	} hsv_pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		bit               pinned;
		hsv_pix_t         want;
	} pixel_row_t;

	logic clk;
	logic arst_n;

	rhsv_rgb_if rgb_ch ();
	rhsv_hsv_if hsv_ch ();

	rgb_to_hsv_pixel_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rgb    (rgb_ch),
		.hsv    (hsv_ch)
	);

	hsv_pix_t pending_hsv [$];
	hsv_pix_t oldest_hsv;
	int       mismatches    = 0;
	int       src_idle_pct  = 17;
	int       sink_idle_pct = 85;

	// Directed pixels; pinned rows carry a result known by inspection
	pixel_row_t pixel_rows [N_ROWS] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},   // black
		'{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}}, // white
		'{8'd128, 8'd128, 8'd128, 1'b1, '{8'd0,   8'd0,   8'd128}}, // mid gray
		'{8'd1,   8'd1,   8'd1,   1'b1, '{8'd0,   8'd0,   8'd1}},   // darkest gray
		'{8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd255}}, // pure red
		'{8'd0,   8'd255, 8'd0,   1'b1, '{8'd85,  8'd255, 8'd255}}, // pure green
		'{8'd0,   8'd0,   8'd255, 1'b1, '{8'd170, 8'd255, 8'd255}}, // pure blue
		'{8'd1,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd1}},   // dimmest red
		'{8'd255, 8'd255, 8'd0,   1'b0, '0},  // green ties red
		'{8'd0,   8'd255, 8'd255, 1'b0, '0},  // blue ties green
		'{8'd255, 8'd0,   8'd255, 1'b0, '0},  // blue ties red
		'{8'd255, 8'd0,   8'd1,   1'b0, '0},  // red sector wraps, top hue
		'{8'd200, 8'd10,  8'd150, 1'b0, '0},  // red sector wraps
		'{8'd0,   8'd1,   8'd0,   1'b0, '0},
		'{8'd0,   8'd0,   8'd1,   1'b0, '0},
		'{8'd255, 8'd254, 8'd254, 1'b0, '0},  // chroma of one
		'{8'd254, 8'd255, 8'd255, 1'b0, '0},
		'{8'd170, 8'd85,  8'd85,  1'b0, '0},
		'{8'd85,  8'd170, 8'd170, 1'b0, '0},
		'{8'd170, 8'd170, 8'd85,  1'b0, '0},
		'{8'd1,   8'd254, 8'd128, 1'b0, '0}
	};

	// Convert one pixel with exact integer floors
	function automatic hsv_pix_t convert_rgb_to_hsv(input logic [PIX_W-1:0] r,
			input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
		int       ri, gi, bi, peak, floor_v, chroma, arc;
		hsv_pix_t res;
		ri      = int'(r);
		gi      = int'(g);
		bi      = int'(b);
		peak    = (ri > gi) ? ri : gi;
		peak    = (peak > bi) ? peak : bi;
		floor_v = (ri < gi) ? ri : gi;
		floor_v = (floor_v < bi) ? floor_v : bi;
		chroma  = peak - floor_v;
		res     = '0;
		res.value = peak[PIX_W-1:0];
		if (peak != 0) begin
			res.saturation = PIX_W'((FULL * chroma) / peak);
		end
		if (chroma != 0) begin
			// pick the sector; blue beats green beats red on ties
			if (peak == bi) begin
				arc = DEG_BLUE * chroma + DEG_SIXTH * (ri - gi);
			end else if (peak == gi) begin
				arc = DEG_GREEN * chroma + DEG_SIXTH * (bi - ri);
			end else begin
				arc = DEG_SIXTH * (gi - bi);
			end
			if (arc < 0) begin
				arc = arc + DEG_TURN * chroma;
			end
			res.hue = PIX_W'((arc * FULL) / (DEG_TURN * chroma));
		end
		return res;
	endfunction

	// Offer one pixel, idle at random first, and queue its result on acceptance
	task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b, input hsv_pix_t due);
		while ($urandom_range(99) < src_idle_pct) begin
			rgb_ch.valid <= 1'b0;
			rgb_ch.red   <= PIX_W'($urandom);
			rgb_ch.green <= PIX_W'($urandom);
			rgb_ch.blue  <= PIX_W'($urandom);
			@(negedge clk);
		end
		rgb_ch.valid <= 1'b1;
		rgb_ch.red   <= r;
		rgb_ch.green <= g;
		rgb_ch.blue  <= b;
		do begin
			@(posedge clk);
		end while (!rgb_ch.ready);
		pending_hsv.push_back(due);
		@(negedge clk);
	endtask

	// Pick a channel level from the corners of the range
	function automatic logic [PIX_W-1:0] corner_level();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd127;
			3: return 8'd128;
			4: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Toggle the result-side ready at random
	initial begin
		hsv_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			hsv_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		if (hsv_ch.valid && hsv_ch.ready) begin
			if (pending_hsv.size() == 0) begin
				$error("unexpected result hue=%0d saturation=%0d value=%0d",
					hsv_ch.hue, hsv_ch.saturation, hsv_ch.value);
				mismatches++;
			end else begin
				oldest_hsv = pending_hsv.pop_front();
				if (hsv_ch.hue !== oldest_hsv.hue) begin
					$error("hue: expected %0d, got %0d", oldest_hsv.hue, hsv_ch.hue);
					mismatches++;
				end
				if (hsv_ch.saturation !== oldest_hsv.saturation) begin
					$error("saturation: expected %0d, got %0d",
						oldest_hsv.saturation, hsv_ch.saturation);
					mismatches++;
				end
				if (hsv_ch.value !== oldest_hsv.value) begin
					$error("value: expected %0d, got %0d", oldest_hsv.value, hsv_ch.value);
					mismatches++;
				end
			end
		end
	end

	// Stimulus: reset, directed rows, three random phases, drain
	initial begin
		int               idx, phase, cnt, waited;
		logic [PIX_W-1:0] r, g, b, lvl;
		hsv_pix_t         due;
		arst_n       = 1'b0;
		rgb_ch.valid <= 1'b0;
		rgb_ch.red   <= '0;
		rgb_ch.green <= '0;
		rgb_ch.blue  <= '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (idx = 0; idx < N_ROWS; idx++) begin
			due = pixel_rows[idx].pinned ? pixel_rows[idx].want :
				convert_rgb_to_hsv(pixel_rows[idx].red, pixel_rows[idx].green,
					pixel_rows[idx].blue);
			send_pixel(pixel_rows[idx].red, pixel_rows[idx].green, pixel_rows[idx].blue, due);
		end

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin src_idle_pct = 17; sink_idle_pct = 85; cnt = 600; end
				1: begin src_idle_pct = 85; sink_idle_pct = 17; cnt = 600; end
				default: begin src_idle_pct = 0; sink_idle_pct = 0; cnt = 550; end
			endcase
			for (idx = 0; idx < cnt; idx++) begin
				r = PIX_W'($urandom);
				g = PIX_W'($urandom);
				b = PIX_W'($urandom);
				// shape the pixel toward grays, ties, low chroma, zero or full channels and corners
				case ($urandom_range(9))
					4: begin g = r; b = r; end
					5: begin
						lvl = PIX_W'($urandom_range(255, 1));
						case ($urandom_range(2))
							0: begin
								b = PIX_W'($urandom_range(lvl - 1));
								r = lvl;
								g = lvl;
							end
							1: begin
								r = PIX_W'($urandom_range(lvl - 1));
								g = lvl;
								b = lvl;
							end
							default: begin
								g = PIX_W'($urandom_range(lvl - 1));
								r = lvl;
								b = lvl;
							end
						endcase
					end
					6: begin
						lvl = PIX_W'($urandom_range(253));
						r = lvl + PIX_W'($urandom_range(2));
						g = lvl + PIX_W'($urandom_range(2));
						b = lvl + PIX_W'($urandom_range(2));
					end
					7: begin
						case ($urandom_range(2))
							0: r = '0;
							1: g = '0;
							default: b = '0;
						endcase
					end
					8: begin r = corner_level(); g = corner_level(); b = corner_level(); end
					9: begin
						case ($urandom_range(2))
							0: r = 8'd255;
							1: g = 8'd255;
							default: b = 8'd255;
						endcase
					end
					default: ;
				endcase
				send_pixel(r, g, b, convert_rgb_to_hsv(r, g, b));
			end
		end
		rgb_ch.valid <= 1'b0;

		// drain outstanding results
		waited = 0;
		while (pending_hsv.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_hsv.size() != 0) begin
			$error("%0d results never arrived", pending_hsv.size());
			mismatches++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Hard stop for a hung run
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/rhsv_pkg.sv
rtl/core/rhsv_rgb_if.sv
rtl/core/rhsv_hsv_if.sv
rtl/core/rhsv_front.sv
rtl/core/rhsv_div_stage.sv
rtl/core/rgb_to_hsv_pixel_core.sv
dv/tb.sv
